>>> design/mpd_pkg.sv
// shared types and constants for the multichannel pid deadband drive
// no dependencies; used by mpd_state, mpd_law and the top level
package mpd_pkg;

   // operation codes carried in the request tuser
   localparam logic [2:0] OP_STOP_CLEAR = 3'd0;
   localparam logic [2:0] OP_CONTROL    = 3'd1;
   localparam logic [2:0] OP_PASS       = 3'd2;
   localparam logic [2:0] OP_STOP_HOLD  = 3'd3;

   // control register indexes
   localparam int          REG_INDEX_W     = 3;
   localparam int          REG_DATA_W      = 16;
   localparam logic [2:0]  REG_GAIN_P      = 3'd0;
   localparam logic [2:0]  REG_GAIN_I      = 3'd1;
   localparam logic [2:0]  REG_GAIN_D      = 3'd2;
   localparam logic [2:0]  REG_DEAD_BAND   = 3'd3;
   localparam logic [2:0]  REG_DRIVE_LIMIT = 3'd4;

   localparam logic [7:0]  DRIVE_LIMIT_RESET = 8'd100;

   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic        [14:0] dead_band;
      logic        [7:0]  drive_limit;
   } gains_type;

   localparam gains_type GAINS_RESET = '{
      gain_p:      16'sd0,
      gain_i:      16'sd0,
      gain_d:      16'sd0,
      dead_band:   15'd0,
      drive_limit: DRIVE_LIMIT_RESET
   };

   // per channel controller state
   typedef struct packed {
      logic signed [31:0] integral;
      logic signed [16:0] last_error;
      logic signed [15:0] last_setpoint;
   } state_entry_type;

   typedef struct packed {
      logic signed [8:0] drive;
      logic              clipped;
   } drive_result_type;

endpackage

>>> design/mpd_state.sv
// per channel controller state registers, one read port and one write port
// depends on mpd_pkg
module mpd_state #(
   parameter int  CHANNELS = 4,
   localparam int IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [IdxW-1:0]          rd_idx,
   output mpd_pkg::state_entry_type rd_entry,
   input  logic                     wr_en,
   input  logic [IdxW-1:0]          wr_idx,
   input  mpd_pkg::state_entry_type wr_entry
);

   mpd_pkg::state_entry_type entries_ff [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            entries_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entries_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_entry = entries_ff[rd_idx];

endmodule

>>> design/mpd_law.sv
// control law for one word: pid with deadband, pass-through and stop modes
// depends on mpd_pkg; pure combinational logic
module mpd_law (
   input  logic [2:0]                operation,
   input  logic                      chan_ok,
   input  logic signed [15:0]        setpoint,
   input  logic signed [15:0]        measured,
   input  mpd_pkg::state_entry_type  cur,
   input  mpd_pkg::gains_type        gains,
   output mpd_pkg::state_entry_type  nxt,
   output logic                      upd,
   output mpd_pkg::drive_result_type result
);

   // saturate a sign and magnitude to +/- limit
   function automatic mpd_pkg::drive_result_type clamp_drive(
      input logic        neg,
      input logic [33:0] mag,
      input logic [7:0]  limit
   );
      mpd_pkg::drive_result_type res;
      logic [8:0]                m9;
      if (mag > {26'd0, limit}) begin
         res.clipped = 1'b1;
         m9          = {1'b0, limit};
      end else begin
         res.clipped = 1'b0;
         m9          = mag[8:0];
      end
      res.drive = neg ? $signed(9'(~m9 + 9'd1)) : $signed(m9);
      return res;
   endfunction

   logic signed [16:0]        e_raw;
   logic        [16:0]        e_mag;
   logic signed [16:0]        err;
   logic signed [31:0]        i_cur;
   logic signed [16:0]        le_cur;
   logic signed [17:0]        de;
   logic signed [32:0]        prod_p;
   logic signed [33:0]        prod_d;
   logic signed [47:0]        prod_i;
   logic signed [49:0]        acc;
   logic        [49:0]        acc_mag;
   logic        [33:0]        round_mag;
   logic signed [32:0]        i_sum;
   logic signed [31:0]        i_next;
   logic        [16:0]        sp_mag;
   mpd_pkg::drive_result_type pid_res;
   mpd_pkg::drive_result_type pass_res;

   always_comb begin
      e_raw  = 17'(setpoint) - 17'(measured);
      e_mag  = e_raw[16] ? 17'(-e_raw) : 17'(e_raw);
      err    = (e_mag < {2'b00, gains.dead_band}) ? '0 : e_raw;

      // a new setpoint restarts the integral, an empty integral drops the old error
      i_cur  = (setpoint != cur.last_setpoint) ? '0 : cur.integral;
      le_cur = (i_cur == '0) ? '0 : cur.last_error;
      de     = 18'(err) - 18'(le_cur);

      prod_p = 33'(gains.gain_p) * 33'(err);
      prod_d = 34'(gains.gain_d) * 34'(de);
      prod_i = 48'(gains.gain_i) * 48'(i_cur);
      acc    = 50'(prod_p) + 50'(prod_d) + 50'(prod_i);

      // round Q8.8 x Q8.8 to integer, halves away from zero
      acc_mag   = acc[49] ? 50'(-acc) : 50'(acc);
      round_mag = 34'((acc_mag + 50'd32768) >> 16);
      pid_res   = clamp_drive(acc[49], round_mag, gains.drive_limit);

      // integral saturates at the signed 32 bit range
      i_sum  = 33'(i_cur) + 33'(err);
      i_next = (i_sum[32] != i_sum[31]) ? {i_sum[32], {31{~i_sum[32]}}} : i_sum[31:0];

      // pass-through truncates toward zero
      sp_mag   = setpoint[15] ? 17'(-17'(setpoint)) : 17'(setpoint);
      pass_res = clamp_drive(setpoint[15], 34'(sp_mag[16:8]), gains.drive_limit);

      nxt = cur;
      case (operation)
         mpd_pkg::OP_CONTROL: begin
            upd               = 1'b1;
            nxt.integral      = i_next;
            nxt.last_error    = err;
            nxt.last_setpoint = setpoint;
            result            = pid_res;
         end
         mpd_pkg::OP_PASS: begin
            upd    = 1'b0;
            result = pass_res;
         end
         mpd_pkg::OP_STOP_HOLD: begin
            upd    = 1'b0;
            result = '0;
         end
         default: begin
            // stop and clear, and every undefined code
            upd          = 1'b1;
            nxt.integral = '0;
            result       = '0;
         end
      endcase

      if (!chan_ok) begin
         upd    = 1'b0;
         result = '0;
      end
   end

endmodule

>>> design/multichannel_pid_deadband_drive.sv
// top level of the multichannel pid deadband drive: stream ports, control
// registers, input and result registers; uses mpd_pkg, mpd_state, mpd_law
// an accepted request word is held in the input register and moves on into the
//   result register once that register is empty or being taken
// throughput: one word per cycle while the result stream does not stall, set by the
//   single-stage read-modify-write of the channel state between the two registers
// reset: clears the valid flags and all channel state, gains and deadband to 0,
//   drive limit to 100
module multichannel_pid_deadband_drive #(
   parameter int  CHANNELS = 4,
   localparam int IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,

   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,  // channel, setpoint, measured, zero pad
   input  logic [2:0]                      req_tuser,  // operation

   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // out_channel, drive, zero pad
   output logic [0:0]                      rsp_tuser,  // clipped

   // control register writes
   input  logic                            csr_we,
   input  logic [mpd_pkg::REG_INDEX_W-1:0] csr_addr,
   input  logic [mpd_pkg::REG_DATA_W-1:0]  csr_wdata
);

   // control registers
   mpd_pkg::gains_type gains_ff, gains_in;

   // input register
   logic               in_valid_ff,   in_valid_in;
   logic [1:0]         in_channel_ff, in_channel_in;
   logic [2:0]         in_op_ff,      in_op_in;
   logic signed [15:0] in_sp_ff,      in_sp_in;
   logic signed [15:0] in_meas_ff,    in_meas_in;

   // result register
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [1:0]         rsp_channel_ff, rsp_channel_in;
   mpd_pkg::drive_result_type rsp_res_ff, rsp_res_in;

   // datapath
   logic                      advance;
   logic                      move;
   logic                      chan_ok;
   logic [IdxW-1:0]           ch_idx;
   mpd_pkg::state_entry_type  cur_entry;
   mpd_pkg::state_entry_type  nxt_entry;
   logic                      law_upd;
   mpd_pkg::drive_result_type law_res;
   logic [8:0]                lim_pos;
   logic [8:0]                lim_neg;

   // result register frees up when empty or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign move       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // control register decode
   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mpd_pkg::REG_GAIN_P:      gains_in.gain_p      = signed'(csr_wdata);
            mpd_pkg::REG_GAIN_I:      gains_in.gain_i      = signed'(csr_wdata);
            mpd_pkg::REG_GAIN_D:      gains_in.gain_d      = signed'(csr_wdata);
            mpd_pkg::REG_DEAD_BAND:   gains_in.dead_band   = csr_wdata[14:0];
            mpd_pkg::REG_DRIVE_LIMIT: gains_in.drive_limit = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register loads whenever it is empty or hands its word on
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_channel_in = in_channel_ff;
      in_op_in      = in_op_ff;
      in_sp_in      = in_sp_ff;
      in_meas_in    = in_meas_ff;
      if (req_tready) begin
         in_valid_in   = req_tvalid;
         in_channel_in = req_tdata[1:0];
         in_op_in      = req_tuser;
         in_sp_in      = signed'(req_tdata[17:2]);
         in_meas_in    = signed'(req_tdata[33:18]);
      end
   end

   // channel state lookup, words for channels past the table leave the state alone and give a zero drive
   assign chan_ok = 32'(in_channel_ff) < CHANNELS;
   assign ch_idx  = IdxW'(in_channel_ff);

   mpd_state #(
      .CHANNELS (CHANNELS)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (ch_idx),
      .rd_entry (cur_entry),
      .wr_en    (move && law_upd),
      .wr_idx   (ch_idx),
      .wr_entry (nxt_entry)
   );

   mpd_law u_law (
      .operation (in_op_ff),
      .chan_ok   (chan_ok),
      .setpoint  (in_sp_ff),
      .measured  (in_meas_ff),
      .cur       (cur_entry),
      .gains     (gains_ff),
      .nxt       (nxt_entry),
      .upd       (law_upd),
      .result    (law_res)
   );

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_res_in     = rsp_res_ff;
      if (advance) begin
         rsp_valid_in   = in_valid_ff;
         rsp_channel_in = in_channel_ff;
         rsp_res_in     = law_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff     <= mpd_pkg::GAINS_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gains_ff     <= gains_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_channel_ff  <= in_channel_in;
      in_op_ff       <= in_op_in;
      in_sp_ff       <= in_sp_in;
      in_meas_ff     <= in_meas_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_res_ff     <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_res_ff.drive, rsp_channel_ff};
   assign rsp_tuser  = rsp_res_ff.clipped;

   // signed drive limit for the checks below
   assign lim_pos = {1'b0, gains_ff.drive_limit};
   assign lim_neg = 9'(~lim_pos + 9'd1);

   // backpressure only when both registers hold a word and the output stalls
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a full pipeline");

   // a word that moves on is presented on the result side next cycle
   a_word_moves: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_tvalid)
      else $error("word lost between input and result register");

   // a clipped drive sits exactly at the limit
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && law_res.clipped) |->
         (law_res.drive == lim_pos || law_res.drive == lim_neg))
      else $error("clipped drive not at the limit");

   // an unclipped drive never exceeds the limit
   a_drive_bounded: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !law_res.clipped) |->
         (law_res.drive <= $signed(lim_pos) && law_res.drive >= $signed(lim_neg)))
      else $error("drive beyond limit without clip");

endmodule
